@@ rtl/dotq_pkg.sv @@
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared constants, codes and controller/datapath interface types for the
// deadline ordered transfer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int UNIT_BYTES  = 512;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int PTR_W       = IDX_W + 1;
  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_ENQUEUE      = 2'd0,
    OP_SET_DEADLINE = 2'd1,
    OP_TICK         = 2'd2,
    OP_QUERY        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FIND,
    S_RESTART,
    S_PLACE,
    S_TICK
  } state_t;

  typedef enum logic [1:0] {
    ADDR_CUR,
    ADDR_FREE,
    ADDR_HEAD
  } addr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      latch;      // capture input beat
    logic      walk_init;  // cur = head, prev = none, steps = 0
    logic      step;       // advance walk one entry
    logic      alloc;      // pop free slot, write payload
    logic      found;      // store new deadline, unlink entry at cur
    logic      link_in;    // splice slot before cur
    logic      tick;       // unit copy from head
    logic      respond;    // load result register
    addr_sel_t addr_sel;
    status_t   rsp_status;
    logic      rsp_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic walk_end;
    logic id_match;
    logic place_stop;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/dotq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dotq_ctrl
// Sequencer: decodes the operation and steps the list walks.
// ----------------------------------------------------------------------------
module dotq_ctrl import dotq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  op_t   in_op,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.addr_sel   = ADDR_CUR;
    cmd.rsp_status = ST_OK;
    in_tready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.latch     = 1'b1;
          cmd.walk_init = 1'b1;
          case (in_op)
            OP_ENQUEUE: state_nxt = S_ALLOC;
            OP_TICK:    state_nxt = S_TICK;
            default:    state_nxt = S_FIND;
          endcase
        end
      end
      S_ALLOC: begin
        cmd.addr_sel = ADDR_FREE;
        if (st.full) begin
          if (st.out_free) begin
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_FULL;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.alloc = 1'b1;
          state_nxt = S_PLACE;
        end
      end
      S_FIND: begin
        if (st.walk_end) begin
          if (st.out_free) begin
            cmd.respond = 1'b1;
            if (st.op == OP_QUERY) begin
              cmd.rsp_done = 1'b1;
            end else begin
              cmd.rsp_status = ST_NOT_FOUND;
            end
            state_nxt = S_IDLE;
          end
        end else if (st.id_match) begin
          if (st.op == OP_QUERY) begin
            if (st.out_free) begin
              cmd.respond = 1'b1;
              state_nxt   = S_IDLE;
            end
          end else begin
            cmd.found = 1'b1;
            state_nxt = S_RESTART;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_RESTART: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_PLACE;
      end
      S_PLACE: begin
        if (st.place_stop) begin
          if (st.out_free) begin
            cmd.link_in = 1'b1;
            cmd.respond = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_TICK: begin
        cmd.addr_sel = ADDR_HEAD;
        if (st.out_free) begin
          cmd.tick    = 1'b1;
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/dotq_dp.sv @@
// ----------------------------------------------------------------------------
// dotq_dp
// Slot stores, link list, walk pointers and result register.
// ----------------------------------------------------------------------------
module dotq_dp import dotq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output stat_t        st,
  input  logic [1:0]   in_op,
  input  logic [151:0] in_data,
  output logic         out_valid,
  input  logic         out_tready,
  output logic [87:0]  out_data,
  output logic [1:0]   out_status
);

  // slot stores
  logic [15:0]      id_mem  [QUEUE_DEPTH];
  logic [47:0]      dl_mem  [QUEUE_DEPTH];
  logic [31:0]      src_mem [QUEUE_DEPTH];
  logic [31:0]      dst_mem [QUEUE_DEPTH];
  logic [23:0]      rem_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] link_r  [QUEUE_DEPTH];

  logic [PTR_W-1:0] head_r, free_r, count_r, cur_r, prev_r, steps_r;
  logic [IDX_W-1:0] s_r;
  op_t              op_r;
  logic [15:0]      id_r;
  logic [47:0]      dl_r;
  logic [31:0]      src_r, dst_r;
  logic [23:0]      size_r;
  logic             out_valid_r;
  logic [87:0]      out_data_r;
  status_t          out_status_r;

  logic [IDX_W-1:0] rd_addr;
  logic [PTR_W-1:0] rd_link;
  logic [47:0]      rd_dl;
  logic [23:0]      rem_new;
  logic             empty, retire, walk_end;
  logic [PTR_W-1:0] count_nxt;
  logic             cv;
  logic [31:0]      csrc, cdst;
  logic [15:0]      fid;
  status_t          rsp_status;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_FREE: rd_addr = free_r[IDX_W-1:0];
      ADDR_HEAD: rd_addr = head_r[IDX_W-1:0];
      default:   rd_addr = cur_r[IDX_W-1:0];
    endcase
  end

  assign rd_link  = link_r[rd_addr];
  assign rd_dl    = dl_mem[rd_addr];
  assign walk_end = (cur_r >= NO_SLOT) || (steps_r >= NO_SLOT);

  assign st.op         = op_r;
  assign st.full       = (count_r >= NO_SLOT) || (free_r >= NO_SLOT);
  assign st.walk_end   = walk_end;
  assign st.id_match   = (id_mem[rd_addr] == id_r);
  assign st.place_stop = walk_end ||
                         ((dl_r != 48'd0) && ((rd_dl == 48'd0) || (rd_dl > dl_r)));
  assign st.out_free   = !out_valid_r || out_tready;

  // tick arithmetic, remaining size saturates at zero
  assign empty   = (head_r >= NO_SLOT) || (count_r == '0);
  assign rem_new = (rem_mem[rd_addr] > 24'(UNIT_BYTES)) ?
                   rem_mem[rd_addr] - 24'(UNIT_BYTES) : 24'd0;
  assign retire  = cmd.tick && !empty && (rem_new == 24'd0);

  always_comb begin
    count_nxt = count_r;
    if (cmd.link_in && op_r == OP_ENQUEUE) count_nxt = count_r + 1'b1;
    else if (retire)                       count_nxt = count_r - 1'b1;
  end

  assign cv         = cmd.tick && !empty;
  assign csrc       = cv ? src_mem[rd_addr] : 32'd0;
  assign cdst       = cv ? dst_mem[rd_addr] : 32'd0;
  assign fid        = retire ? id_mem[rd_addr] : 16'd0;
  assign rsp_status = (cmd.tick && empty) ? ST_EMPTY : cmd.rsp_status;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) link_r[i] <= PTR_W'(i + 1);
      head_r      <= NO_SLOT;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.alloc) free_r <= rd_link;
      if (cmd.found) begin
        if (prev_r < NO_SLOT) link_r[prev_r[IDX_W-1:0]] <= rd_link;
        else                  head_r <= rd_link;
      end
      if (cmd.link_in) begin
        link_r[s_r] <= cur_r;
        if (prev_r < NO_SLOT) link_r[prev_r[IDX_W-1:0]] <= {1'b0, s_r};
        else                  head_r <= {1'b0, s_r};
      end
      if (retire) begin
        head_r          <= rd_link;
        link_r[rd_addr] <= free_r;
        free_r          <= head_r;
      end
      if (cmd.respond)  out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload, walk pointers, result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_op);
      id_r   <= in_data[15:0];
      dl_r   <= in_data[63:16];
      src_r  <= in_data[95:64];
      dst_r  <= in_data[127:96];
      size_r <= in_data[151:128];
    end
    if (cmd.walk_init) begin
      cur_r   <= head_r;
      prev_r  <= NO_SLOT;
      steps_r <= '0;
    end else if (cmd.step) begin
      prev_r  <= cur_r;
      cur_r   <= rd_link;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.alloc) begin
      s_r              <= rd_addr;
      id_mem[rd_addr]  <= id_r;
      dl_mem[rd_addr]  <= dl_r;
      src_mem[rd_addr] <= src_r;
      dst_mem[rd_addr] <= dst_r;
      rem_mem[rd_addr] <= size_r;
    end
    if (cmd.found) begin
      s_r             <= rd_addr;
      dl_mem[rd_addr] <= dl_r;
    end
    if (cv) begin
      src_mem[rd_addr] <= src_mem[rd_addr] + 32'(UNIT_BYTES);
      dst_mem[rd_addr] <= dst_mem[rd_addr] + 32'(UNIT_BYTES);
      rem_mem[rd_addr] <= rem_new;
    end
    if (cmd.respond) begin
      out_status_r <= rsp_status;
      out_data_r   <= {count_nxt, cmd.rsp_done, fid, retire, cdst, csrc, cv};
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NO_SLOT) else $error("queue count above depth");

  // a moved entry is briefly off the list, so only an empty count forces no head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == NO_SLOT)) else $error("count and head disagree");

  a_retire_free: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> free_r != NO_SLOT) else $error("retired slot not on free list");

endmodule

@@ rtl/deadline_ordered_transfer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_ordered_transfer_queue
// Earliest-deadline-first copy request queue with linked-list ordering.
// ----------------------------------------------------------------------------
// Sequence: tick passes IDLE, TICK; enqueue passes IDLE, ALLOC and, unless full,
//   a PLACE walk; query walks in FIND; set deadline walks in FIND, RESTART, PLACE.
// Throughput: one beat at a time; list walks visit one entry per cycle
//   through the single read port of the slot stores.
// Reset: rst_n synchronous, active low; queue empty, free list 0..last.
module deadline_ordered_transfer_queue import dotq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] request_id, [63:16] deadline, [95:64] source_address,
  // [127:96] dest_address, [151:128] transfer_size
  input  logic [151:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] copy_valid, [32:1] copy_source, [64:33] copy_dest,
  // [65] request_finished, [81:66] finished_id, [82] transfer_done,
  // [87:83] entry_count
  output logic [87:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser
);

  cmd_t  cmd;
  stat_t st;

  // sequencer: one beat in flight, result register decouples the output
  dotq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (op_t'(in_tuser)),
    .st        (st),
    .cmd       (cmd)
  );

  // slot stores and link list, walked one entry per cycle
  dotq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_op      (in_tuser),
    .in_data    (in_tdata),
    .out_valid  (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser)
  );

endmodule

@@ bench/deadline_ordered_transfer_queue_test.sv @@
// ----------------------------------------------------------------------------
// deadline_ordered_transfer_queue_test
// Self-checking bench: streams enqueue, set-deadline, tick and query beats
// into the queue, predicts every response with a behavioral list model and
// compares each response beat field by field, with random stalls both sides.
// ----------------------------------------------------------------------------
module deadline_ordered_transfer_queue_test;
  import dotq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [23:0] size;
    logic [31:0] dst;
    logic [31:0] src;
    logic [47:0] dline;
    logic [15:0] id;
    op_t         op;
  } req_t;

  typedef struct packed {
    logic [4:0]  count;
    logic        done;
    logic [15:0] fin_id;
    logic        fin;
    logic [31:0] cdst;
    logic [31:0] csrc;
    logic        cvalid;
    status_t     status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [151:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0] out_tuser;

  deadline_ordered_transfer_queue dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Model state: slots linked by index, QUEUE_DEPTH marks the end of a chain.
  logic [15:0] m_id   [QUEUE_DEPTH];
  logic [47:0] m_dl   [QUEUE_DEPTH];
  logic [31:0] m_src  [QUEUE_DEPTH];
  logic [31:0] m_dst  [QUEUE_DEPTH];
  logic [23:0] m_rem  [QUEUE_DEPTH];
  int          m_link [QUEUE_DEPTH];
  int m_head, m_free, m_count;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_retired = 0;
  bit   quiet_in = 1'b0, quiet_out = 1'b0;
  bit   hold_send = 1'b0;
  int   idle_cycles = 0;

  function automatic int find_id(logic [15:0] id, output int prev);
    int cur = m_head;
    prev = QUEUE_DEPTH;
    while (cur < QUEUE_DEPTH) begin
      if (m_id[cur] == id) return cur;
      prev = cur;
      cur = m_link[cur];
    end
    prev = QUEUE_DEPTH;
    return QUEUE_DEPTH;
  endfunction

  // Deadline 0 goes to the tail; otherwise ahead of first 0 or later deadline.
  function automatic void place(int s);
    int cur = m_head;
    int prev = QUEUE_DEPTH;
    while (cur < QUEUE_DEPTH) begin
      if (m_dl[s] != 0 && (m_dl[cur] == 0 || m_dl[cur] > m_dl[s])) break;
      prev = cur;
      cur = m_link[cur];
    end
    m_link[s] = cur;
    if (prev < QUEUE_DEPTH) m_link[prev] = s;
    else m_head = s;
  endfunction

  function automatic rsp_t queue_step(req_t r);
    rsp_t o = '0;
    int s, prev;
    case (r.op)
      OP_ENQUEUE: begin
        if (m_count >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          s = m_free;
          m_free = m_link[s];
          m_id[s] = r.id; m_dl[s] = r.dline;
          m_src[s] = r.src; m_dst[s] = r.dst; m_rem[s] = r.size;
          place(s);
          m_count++;
        end
      end
      OP_SET_DEADLINE: begin
        s = find_id(r.id, prev);
        if (s >= QUEUE_DEPTH) begin
          o.status = ST_NOT_FOUND;
        end else begin
          m_dl[s] = r.dline;
          if (prev < QUEUE_DEPTH) m_link[prev] = m_link[s];
          else m_head = m_link[s];
          place(s);
        end
      end
      OP_TICK: begin
        s = m_head;
        if (s >= QUEUE_DEPTH) begin
          o.status = ST_EMPTY;
        end else begin
          o.cvalid = 1'b1;
          o.csrc = m_src[s];
          o.cdst = m_dst[s];
          m_src[s] = m_src[s] + 32'(UNIT_BYTES);
          m_dst[s] = m_dst[s] + 32'(UNIT_BYTES);
          m_rem[s] = (m_rem[s] > 24'(UNIT_BYTES)) ? m_rem[s] - 24'(UNIT_BYTES) : '0;
          if (m_rem[s] == 0) begin
            o.fin = 1'b1;
            o.fin_id = m_id[s];
            m_head = m_link[s];
            m_link[s] = m_free;
            m_free = s;
            m_count--;
          end
        end
      end
      default: begin
        s = find_id(r.id, prev);
        o.done = (s >= QUEUE_DEPTH);
      end
    endcase
    o.count = m_count[4:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Driver: next beat presented once the previous one is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(queue_step(req_t'({in_tdata, in_tuser})));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && !hold_send
            && (quiet_in || $urandom_range(99) >= 6)) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          {in_tdata, in_tuser} <= r;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rsp_t g, e;
        g = rsp_t'({out_tdata, out_tuser});
        if (expected_rsps.size() == 0) begin
          $display("[%0t] response beat with nothing expected", $realtime);
          n_errors++;
        end else begin
          e = expected_rsps.pop_front();
          n_checked++;
          if (e.fin) n_retired++;
          if (g.status !== e.status)
            report_mismatch("status", 48'(g.status), 48'(e.status));
          if (g.cvalid !== e.cvalid)
            report_mismatch("copy_valid", 48'(g.cvalid), 48'(e.cvalid));
          if (g.csrc !== e.csrc)
            report_mismatch("copy_source", 48'(g.csrc), 48'(e.csrc));
          if (g.cdst !== e.cdst)
            report_mismatch("copy_dest", 48'(g.cdst), 48'(e.cdst));
          if (g.fin !== e.fin)
            report_mismatch("request_finished", 48'(g.fin), 48'(e.fin));
          if (g.fin_id !== e.fin_id)
            report_mismatch("finished_id", 48'(g.fin_id), 48'(e.fin_id));
          if (g.done !== e.done)
            report_mismatch("transfer_done", 48'(g.done), 48'(e.done));
          if (g.count !== e.count)
            report_mismatch("entry_count", 48'(g.count), 48'(e.count));
        end
      end
      out_tready <= quiet_out || ($urandom_range(99) >= 6);
      // watchdog on beats accepted by either side
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_req(op_t op, logic [15:0] id, logic [47:0] dl,
                         logic [31:0] src, logic [31:0] dst, logic [23:0] size);
    req_t r;
    r.op = op; r.id = id; r.dline = dl; r.src = src; r.dst = dst; r.size = size;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  // Ids from a small pool so updates and queries mostly hit, duplicates occur.
  function automatic logic [15:0] pick_id();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
  endfunction

  function automatic logic [47:0] pick_dl();
    case ($urandom_range(5))
      0, 1: return '0;
      2: return 48'hFFFF_FFFF_FFFF;
      3: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [23:0] pick_size();
    case ($urandom_range(7))
      0: return 24'($urandom_range(511));
      1: return 24'hFF_FFFF;
      2: return 24'($urandom);
      default: return 24'(UNIT_BYTES * $urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    int sel;
    for (int i = 0; i < QUEUE_DEPTH; i++) m_link[i] = i + 1;
    m_head = QUEUE_DEPTH; m_free = 0; m_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, unknown ids, field extremes, wrap, size 0, full.
    add_req(OP_TICK, 16'h0, '0, '0, '0, '0);
    add_req(OP_QUERY, 16'hFFFF, '0, '0, '0, '0);
    add_req(OP_SET_DEADLINE, 16'h1234, 48'h5, '0, '0, '0);
    add_req(OP_ENQUEUE, 16'hFFFF, '0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 24'h0);
    add_req(OP_ENQUEUE, 16'h0, 48'hFFFF_FFFF_FFFF, '0, '0, 24'hFF_FFFF);
    add_req(OP_ENQUEUE, 16'hA5A5, 48'h1, 32'hAAAA_5555, 32'h5555_AAAA, 24'd700);
    add_req(OP_SET_DEADLINE, 16'hFFFF, 48'h2, '0, '0, '0);
    add_req(OP_QUERY, 16'h0, '0, '0, '0, '0);
    for (int i = 0; i < 14; i++)
      add_req(OP_ENQUEUE, 16'(i + 1), 48'(i % 3), 32'(i), 32'(i), 24'd512);
    add_req(OP_TICK, '0, '0, '0, '0, '0);
    add_req(OP_TICK, '0, '0, '0, '0, '0);
    add_req(OP_TICK, '0, '0, '0, '0, '0);

    // Pause the sender until the queue has answered everything.
    wait_drained();

    hold_send = 1'b1;
    for (int i = 0; i < 1080; i++) begin
      sel = $urandom_range(99);
      if (sel < 30)
        add_req(OP_ENQUEUE, pick_id(), pick_dl(), $urandom, $urandom, pick_size());
      else if (sel < 45)
        add_req(OP_SET_DEADLINE, pick_id(), pick_dl(), $urandom, $urandom, 24'($urandom));
      else if (sel < 85)
        add_req(OP_TICK, 16'($urandom), 48'({$urandom, $urandom}), $urandom, $urandom,
                24'($urandom));
      else
        add_req(OP_QUERY, pick_id(), 48'({$urandom, $urandom}), $urandom, $urandom,
                24'($urandom));
      if (i == 300) begin
        // stretch with no idling on either side
        hold_send = 1'b0;
        quiet_in = 1'b1; quiet_out = 1'b1;
        wait_drained();
        quiet_in = 1'b0; quiet_out = 1'b0;
        hold_send = 1'b1;
      end
    end
    hold_send = 1'b0;
    wait_drained();
    repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

    $display("checked %0d response beats, %0d requests retired by ticks",
             n_checked, n_retired);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
